// ===== design/pip_pkg.sv =====
// Shared constants, codes and control structs for the point-in-polygon classifier.
package pip_pkg;

  // Default sizes
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_COORD_BITS   = 16;

  // Opcode carried on the input tuser
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Query answer codes
  localparam int POS_W = 2;
  localparam logic [POS_W-1:0] POS_OUTSIDE  = 2'd0;
  localparam logic [POS_W-1:0] POS_BOUNDARY = 2'd1;
  localparam logic [POS_W-1:0] POS_INSIDE   = 2'd2;

  // Width of the output tdata (position padded to a byte)
  localparam int OUT_W = 8;

  // Control of one vertex cell in the ring
  typedef struct packed {
    logic shift;   // take the left neighbor (append)
    logic rotate;  // take the right neighbor, or the head when this is the tail
    logic tail;    // this cell holds the oldest stored vertex
  } cell_ctl_t;

  // Control from the sequencer into the edge unit
  typedef struct packed {
    logic start;   // clear the accumulators for a new query
    logic valid;   // an edge is presented this cycle
  } edge_ctl_t;

  // Status from the edge unit back to the sequencer
  typedef struct packed {
    logic busy;      // edges still in flight
    logic boundary;  // some edge holds the point
    logic winding;   // winding number is nonzero
  } edge_stat_t;

endpackage

// ===== design/pip_cell.sv =====
// One vertex cell of the ring: holds a vertex and passes it to a neighbor.
module pip_cell #(
  parameter int COORD_BITS = pip_pkg::DEF_COORD_BITS
) (
  input  logic                         clk,
  input  pip_pkg::cell_ctl_t           ctl,
  input  logic signed [COORD_BITS-1:0] left_x,
  input  logic signed [COORD_BITS-1:0] left_y,
  input  logic signed [COORD_BITS-1:0] right_x,
  input  logic signed [COORD_BITS-1:0] right_y,
  input  logic signed [COORD_BITS-1:0] head_x,
  input  logic signed [COORD_BITS-1:0] head_y,
  output logic signed [COORD_BITS-1:0] vx,
  output logic signed [COORD_BITS-1:0] vy
);

  // Shift toward the tail on append, rotate toward the head on a walk
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      vx <= left_x;
      vy <= left_y;
    end else if (ctl.rotate) begin
      vx <= ctl.tail ? head_x : right_x;
      vy <= ctl.tail ? head_y : right_y;
    end
  end

endmodule

// ===== design/pip_edge.sv =====
// Edge unit: cross product, boundary test and winding count for one edge per cycle.
module pip_edge #(
  parameter int COORD_BITS = pip_pkg::DEF_COORD_BITS,
  parameter int WN_W       = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pip_pkg::edge_ctl_t           ctl,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output pip_pkg::edge_stat_t          stat
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // Stage 1 registers: differences and compare flags
  logic                 v1;
  logic signed [DW-1:0] dx_e, dy_p, dy_e, dx_p;
  logic                 box1, up1, down1;

  // Stage 2 registers: products
  logic                 v2;
  logic signed [PW-1:0] prod_a, prod_b;
  logic                 box2, up2, down2;

  // Accumulators
  logic                   boundary;
  logic signed [WN_W-1:0] wn;

  logic signed [PW:0] cprod;
  logic               in_x, in_y;

  // Bounding box of the edge against the point
  always_comb begin
    in_x = ((ax <= bx) ? (px >= ax && px <= bx) : (px >= bx && px <= ax));
    in_y = ((ay <= by) ? (py >= ay && py <= by) : (py >= by && py <= ay));
  end

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
    end
  end

  // Stage 1: edge and offset differences
  always_ff @(posedge clk) begin
    dx_e  <= DW'(bx) - DW'(ax);
    dy_p  <= DW'(py) - DW'(ay);
    dy_e  <= DW'(by) - DW'(ay);
    dx_p  <= DW'(px) - DW'(ax);
    box1  <= in_x && in_y;
    up1   <= (ay <= py) && (by > py);
    down1 <= (ay > py) && (by <= py);
  end

  // Stage 2: the two products of the cross product
  always_ff @(posedge clk) begin
    prod_a <= PW'(dx_e) * PW'(dy_p);
    prod_b <= PW'(dy_e) * PW'(dx_p);
    box2   <= box1;
    up2    <= up1;
    down2  <= down1;
  end

  assign cprod = (PW + 1)'(prod_a) - (PW + 1)'(prod_b);

  // Stage 3: accumulate boundary hit and winding number
  always_ff @(posedge clk) begin
    if (rst || ctl.start) begin
      boundary <= 1'b0;
      wn       <= '0;
    end else if (v2) begin
      if (cprod == '0 && box2) begin
        boundary <= 1'b1;
      end
      if (up2 && cprod > 0) begin
        wn <= wn + WN_W'(1);
      end else if (down2 && cprod < 0) begin
        wn <= wn - WN_W'(1);
      end
    end
  end

  assign stat.busy     = ctl.valid | v1 | v2;
  assign stat.boundary = boundary;
  assign stat.winding  = (wn != '0);

endmodule

// ===== design/point_in_polygon_classifier_top.sv =====
// Point-in-polygon classifier: vertex ring, walk sequencer and result register.
//
// Vertices sit in a ring of MAX_VERTICES cells; an append shifts the ring, a
// clear empties it, and an append to a full ring is dropped. A query rotates
// the ring once, one vertex per cycle, into a single three-stage edge unit
// (differences, products, accumulate); the answer is loaded once the edge unit
// has drained and the output is free, and the next beat is taken in the cycle
// after that. No new beat is taken while a query walks the ring or waits to
// load its answer. Appends and clears are still taken while a query answer
// waits on the output. Opcode rides on s_tuser; the answer is 0 outside,
// 1 on the boundary, 2 inside.
module point_in_polygon_classifier_top #(
  parameter  int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
  parameter  int COORD_BITS   = pip_pkg::DEF_COORD_BITS,
  localparam int IN_W         = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_W-1:0]          s_tdata,   // coord_x, coord_y, zero pad
  input  logic [pip_pkg::OP_W-1:0] s_tuser,   // opcode
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [pip_pkg::OUT_W-1:0] m_tdata   // position, zero pad
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int WN_W  = CNT_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] step;

  logic signed [COORD_BITS-1:0] in_x, in_y;
  logic signed [COORD_BITS-1:0] qx, qy;
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic signed [COORD_BITS-1:0] cx [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] cy [MAX_VERTICES];

  logic                    accept;
  logic                    do_append;
  logic                    walk_rot;
  logic                    out_free;
  logic                    load_out;
  logic [pip_pkg::POS_W-1:0] pos;
  pip_pkg::edge_ctl_t      edge_ctl;
  pip_pkg::edge_stat_t     edge_stat;

  assign in_x = s_tdata[COORD_BITS-1:0];
  assign in_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign do_append = accept && (s_tuser == pip_pkg::OP_APPEND) &&
                     (count != CNT_W'(MAX_VERTICES));
  assign walk_rot  = (state == ST_WALK) && (step != count);
  assign out_free  = !m_tvalid || m_tready;
  assign load_out  = (state == ST_DONE) && !edge_stat.busy && out_free;

  assign edge_ctl.start = accept && (s_tuser == pip_pkg::OP_QUERY);
  assign edge_ctl.valid = (state == ST_WALK) && (step != '0);

  // Vertex ring: newest vertex at cell 0, oldest at cell count-1
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    pip_pkg::cell_ctl_t           cctl;
    logic signed [COORD_BITS-1:0] lx, ly, rx, ry;

    assign cctl.shift  = do_append;
    assign cctl.rotate = walk_rot;
    assign cctl.tail   = (count == CNT_W'(k + 1));

    if (k == 0) begin : g_left_in
      assign lx = in_x;
      assign ly = in_y;
    end else begin : g_left_cell
      assign lx = cx[k-1];
      assign ly = cy[k-1];
    end

    if (k == MAX_VERTICES - 1) begin : g_right_head
      assign rx = cx[0];
      assign ry = cy[0];
    end else begin : g_right_cell
      assign rx = cx[k+1];
      assign ry = cy[k+1];
    end

    pip_cell #(
      .COORD_BITS(COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (cctl),
      .left_x  (lx),
      .left_y  (ly),
      .right_x (rx),
      .right_y (ry),
      .head_x  (cx[0]),
      .head_y  (cy[0]),
      .vx      (cx[k]),
      .vy      (cy[k])
    );
  end

  // Edge from the current head vertex to the previous head vertex held in prev_x/prev_y
  pip_edge #(
    .COORD_BITS(COORD_BITS),
    .WN_W      (WN_W)
  ) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctl  (edge_ctl),
    .ax   (cx[0]),
    .ay   (cy[0]),
    .bx   (prev_x),
    .by   (prev_y),
    .px   (qx),
    .py   (qy),
    .stat (edge_stat)
  );

  // Sequencer, vertex count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !load_out) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              pip_pkg::OP_APPEND: begin
                if (do_append) begin
                  count <= count + CNT_W'(1);
                end
              end
              pip_pkg::OP_QUERY: begin
                state <= ST_WALK;
                step  <= '0;
              end
              pip_pkg::OP_CLEAR: begin
                count <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (step == count) begin
            state <= ST_DONE;
          end else begin
            step <= step + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (load_out) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Answer from the accumulated flags
  always_comb begin
    if (edge_stat.boundary) begin
      pos = pip_pkg::POS_BOUNDARY;
    end else if (edge_stat.winding) begin
      pos = pip_pkg::POS_INSIDE;
    end else begin
      pos = pip_pkg::POS_OUTSIDE;
    end
  end

  // Hold the query point, trail the head vertex, load the answer
  always_ff @(posedge clk) begin
    if (accept && s_tuser == pip_pkg::OP_QUERY) begin
      qx <= in_x;
      qy <= in_y;
    end
    if (state == ST_WALK) begin
      prev_x <= cx[0];
      prev_y <= cy[0];
    end
    if (load_out) begin
      m_tdata <= pip_pkg::OUT_W'(pos);
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !edge_stat.busy)
    else $error("edge unit busy while idle");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("answer loaded outside the done state");

  a_query_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == pip_pkg::OP_QUERY) |=> (state == ST_WALK && step == '0))
    else $error("query did not start a walk");
`endif

endmodule
